// File: rtl/ngfcs_pkg.sv
// Shared constants, register codes and types for the NGF cosine similarity block.
`default_nettype none
package ngfcs_pkg;
    localparam int COUNT_BITS_DEF = 24;
    localparam int GRAD_W         = 16;
    localparam int OPND_W         = 18;
    localparam int PROD_W         = 2 * OPND_W;
    localparam int ACC_W          = 34;
    localparam int NORM_W         = 17;
    localparam int COS_W          = 16;
    localparam int TERM_W         = 17;
    localparam int SUM_W          = 40;
    localparam int MEAN_W         = 18;
    localparam int SIM_W          = 19;
    localparam int CNT_OUT_W      = 25;
    localparam int DIV_NUM_W      = 48;
    localparam int DIV_DEN_W      = 35;
    localparam int ADDR_W         = 4;

    localparam logic [1:0] REG_POWER  = 2'd0;
    localparam logic [1:0] REG_FNORM  = 2'd1;
    localparam logic [1:0] REG_MNORM  = 2'd2;
    localparam logic [1:0] REG_LEGACY = 2'd3;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;
endpackage
`default_nettype wire

// File: rtl/ngfcs_if.sv
// Valid/ready channel interfaces for voxel words and result words.
`default_nettype none
interface ngfcs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] fixed_grad_x;
    logic signed [15:0] fixed_grad_y;
    logic signed [15:0] fixed_grad_z;
    logic signed [15:0] moving_grad_x;
    logic signed [15:0] moving_grad_y;
    logic signed [15:0] moving_grad_z;
    logic               in_foreground;
    logic               last_voxel;
    modport source (output valid, fixed_grad_x, fixed_grad_y, fixed_grad_z,
                    moving_grad_x, moving_grad_y, moving_grad_z, in_foreground,
                    last_voxel, input ready);
    modport sink (input valid, fixed_grad_x, fixed_grad_y, fixed_grad_z,
                  moving_grad_x, moving_grad_y, moving_grad_z, in_foreground,
                  last_voxel, output ready);
endinterface

interface ngfcs_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] similarity_value;
    logic [24:0]        voxels_counted;
    modport source (output valid, similarity_value, voxels_counted, input ready);
    modport sink (input valid, similarity_value, voxels_counted, output ready);
endinterface
`default_nettype wire

// File: rtl/ngfcs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ngfcs_div
    import ngfcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_div_req             i_req,
    output logic                      o_done,
    output logic [DIV_NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   w_rem_sh;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    assign w_rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_den};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[DIV_DEN_W-1:0] : w_rem_sh[DIV_DEN_W-1:0];
            r_quot <= {r_quot[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// File: rtl/ngf_cosine_similarity_mean.sv
// Top level: NGF cosine similarity, streaming mean with APB register port.
// A background voxel that is not last is taken while ready stays high. A foreground voxel
// goes through: accept, 12 shared multiply-adds, two 17-step square roots, one denominator
// multiply, the division, the power steps for the exponent and the accumulate; with a zero norm
// product the division and power steps are skipped. A last voxel then adds the mean division
// (skipped when the count is empty) and the output load, which waits out any output stall.
// Throughput: one voxel at a time; synchronous active-low reset clears sum and count and
// restores the register defaults.
`default_nettype none
module ngf_cosine_similarity_mean
    import ngfcs_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ngfcs_in_if.sink               in_ch,
    ngfcs_out_if.source            out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    localparam int CNT_W = COUNT_BITS + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_SQF  = 4'd2;
    localparam logic [3:0] S_SQM  = 4'd3;
    localparam logic [3:0] S_DEN  = 4'd4;
    localparam logic [3:0] S_CDIV = 4'd5;
    localparam logic [3:0] S_POW  = 4'd6;
    localparam logic [3:0] S_ACC  = 4'd7;
    localparam logic [3:0] S_MST  = 4'd8;
    localparam logic [3:0] S_MDIV = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // configuration registers
    logic [3:0]  r_power;
    logic [15:0] r_fnorm;
    logic [15:0] r_mnorm;
    logic        r_legacy;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power  <= 4'd1;
            r_fnorm  <= 16'd256;
            r_mnorm  <= 16'd256;
            r_legacy <= 1'b0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_POWER:  r_power  <= pwdata[3:0];
                REG_FNORM:  r_fnorm  <= pwdata[15:0];
                REG_MNORM:  r_mnorm  <= pwdata[15:0];
                REG_LEGACY: r_legacy <= pwdata[0];
                default:    r_legacy <= r_legacy;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POWER:  prdata = {28'd0, r_power};
            REG_FNORM:  prdata = {16'd0, r_fnorm};
            REG_MNORM:  prdata = {16'd0, r_mnorm};
            REG_LEGACY: prdata = {31'd0, r_legacy};
            default:    prdata = '0;
        endcase
    end

    // exponent 0 behaves as 1 (odd)
    logic [3:0] w_peff;
    assign w_peff = (r_power == 4'd0) ? 4'd1 : r_power;

    // sequencer and datapath registers
    logic [3:0]               r_state;
    logic [3:0]               r_step;
    logic                     r_last;
    logic signed [OPND_W-1:0] r_f0, r_f1, r_f2, r_f3;
    logic signed [OPND_W-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [ACC_W-1:0]  r_acc_f, r_acc_m, r_acc_d;
    logic [ACC_W-1:0]         r_sq_v, r_sq_r;
    logic [4:0]               r_sq_k;
    logic [NORM_W-1:0]        r_nf, r_nm;
    logic [COS_W-1:0]         r_c, r_pw;
    logic [3:0]               r_pk;
    logic signed [TERM_W-1:0] r_term;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_count;
    logic signed [MEAN_W-1:0] r_mean;
    logic                     r_ovalid;
    logic signed [SIM_W-1:0]  r_osim;
    logic [CNT_OUT_W-1:0]     r_ocnt;

    // shared 18x18 multiplier
    logic signed [OPND_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MAC: begin
                case (r_step[1:0])
                    2'd0:    begin w_ma = r_f0; w_mb = r_m0; end
                    2'd1:    begin w_ma = r_f1; w_mb = r_m1; end
                    2'd2:    begin w_ma = r_f2; w_mb = r_m2; end
                    default: begin w_ma = r_f3; w_mb = r_m3; end
                endcase
                // first group squares fixed, second squares moving
                if (r_step[3:2] == 2'd0) begin
                    w_mb = w_ma;
                end else if (r_step[3:2] == 2'd1) begin
                    w_ma = w_mb;
                end
            end
            S_DEN: begin
                w_ma = {1'b0, r_nf};
                w_mb = {1'b0, r_nm};
            end
            S_POW: begin
                w_ma = {2'b00, r_pw};
                w_mb = {2'b00, r_c};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // square root step
    logic [ACC_W-1:0] w_bit, w_rb, w_sq_r_n, w_sq_v_n;
    assign w_bit = ACC_W'(1) << {r_sq_k, 1'b0};
    assign w_rb  = r_sq_r + w_bit;
    always_comb begin
        if (r_sq_v >= w_rb) begin
            w_sq_v_n = r_sq_v - w_rb;
            w_sq_r_n = (r_sq_r >> 1) + w_bit;
        end else begin
            w_sq_v_n = r_sq_v;
            w_sq_r_n = r_sq_r >> 1;
        end
    end

    // cosine numerator
    logic                     w_neg;
    logic [ACC_W-1:0]         w_dabs;
    logic [DIV_DEN_W-1:0]     w_denom;
    assign w_neg   = r_acc_d[ACC_W-1];
    assign w_dabs  = w_neg ? ACC_W'(-r_acc_d) : ACC_W'(r_acc_d);
    assign w_denom = DIV_DEN_W'(w_prod);

    // power step: (r*c + 2^14) >> 15
    logic [PROD_W-1:0] w_pround;
    assign w_pround = PROD_W'(w_prod) + PROD_W'(16384);

    // divider
    t_div_req             w_req;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quot;

    ngfcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic              w_sneg;
    logic [SUM_W-1:0]  w_sabs;
    assign w_sneg = r_sum[SUM_W-1];
    assign w_sabs = w_sneg ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_comb begin
        w_req = '0;
        if (r_state == S_DEN && w_denom != '0) begin
            w_req.start = 1'b1;
            w_req.num   = {w_dabs[32:0], 15'd0} + DIV_NUM_W'(w_denom >> 1);
            w_req.den   = w_denom;
        end else if (r_state == S_MST && r_count != '0) begin
            w_req.start = 1'b1;
            w_req.num   = DIV_NUM_W'({w_sabs, 1'b0}) + DIV_NUM_W'(r_count >> 1);
            w_req.den   = DIV_DEN_W'(r_count);
        end
    end

    // saturating accumulate
    logic signed [SUM_W:0] w_sum_ext;
    logic signed [SUM_W:0] w_smax, w_smin;
    assign w_smax    = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
    assign w_smin    = ~w_smax;
    assign w_sum_ext = (SUM_W+1)'(r_sum) + (SUM_W+1)'(r_term);

    // result mapping
    logic signed [SIM_W:0] w_one_minus, w_result;
    assign w_one_minus = (SIM_W+1)'(65536) - (SIM_W+1)'(r_mean);
    always_comb begin
        if (r_legacy) begin
            w_result = (SIM_W+1)'(r_mean);
        end else if (!w_peff[0]) begin
            w_result = w_one_minus;
        end else begin
            w_result = (w_one_minus + 2'sb01) >>> 1;
        end
    end

    logic w_out_free;
    assign w_out_free  = !r_ovalid || out_ch.ready;
    assign in_ch.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // load a new result word, else drop the taken one
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        if (in_ch.in_foreground && !r_count[COUNT_BITS]) begin
                            r_state <= S_MAC;
                        end else if (in_ch.last_voxel) begin
                            r_state <= S_MST;
                        end
                        r_step <= '0;
                    end
                end
                S_MAC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd11) begin
                        r_state <= S_SQF;
                    end
                end
                S_SQF: begin
                    if (r_sq_k == '0) begin
                        r_state <= S_SQM;
                    end
                end
                S_SQM: begin
                    if (r_sq_k == '0) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_state <= (w_denom == '0) ? S_ACC : S_CDIV;
                end
                S_CDIV: begin
                    if (w_div_done) begin
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    if (r_pk == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (w_sum_ext > w_smax) begin
                        r_sum <= SUM_W'(w_smax);
                    end else if (w_sum_ext < w_smin) begin
                        r_sum <= SUM_W'(w_smin);
                    end else begin
                        r_sum <= SUM_W'(w_sum_ext);
                    end
                    r_count <= r_count + 1'b1;
                    r_state <= r_last ? S_MST : S_IDLE;
                end
                S_MST: begin
                    r_state <= (r_count == '0) ? S_OUT : S_MDIV;
                end
                S_MDIV: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free, then clear the running mean
                    if (w_out_free) begin
                        r_sum    <= '0;
                        r_count  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_last  <= in_ch.last_voxel;
                r_f0    <= OPND_W'(in_ch.fixed_grad_x);
                r_f1    <= OPND_W'(in_ch.fixed_grad_y);
                r_f2    <= OPND_W'(in_ch.fixed_grad_z);
                r_f3    <= {2'b00, r_fnorm};
                r_m0    <= OPND_W'(in_ch.moving_grad_x);
                r_m1    <= OPND_W'(in_ch.moving_grad_y);
                r_m2    <= OPND_W'(in_ch.moving_grad_z);
                r_m3    <= {2'b00, r_mnorm};
                r_acc_f <= '0;
                r_acc_m <= '0;
                r_acc_d <= '0;
            end
            S_MAC: begin
                case (r_step[3:2])
                    2'd0:    r_acc_f <= r_acc_f + ACC_W'(w_prod);
                    2'd1:    r_acc_m <= r_acc_m + ACC_W'(w_prod);
                    default: r_acc_d <= r_acc_d + ACC_W'(w_prod);
                endcase
                // load the root unit each step; the last load holds the complete fixed squared norm
                r_sq_v <= ACC_W'(r_acc_f);
                r_sq_r <= '0;
                r_sq_k <= 5'd16;
            end
            S_SQF: begin
                if (r_sq_k == '0) begin
                    r_nf   <= w_sq_r_n[NORM_W-1:0];
                    r_sq_v <= ACC_W'(r_acc_m);
                    r_sq_r <= '0;
                    r_sq_k <= 5'd16;
                end else begin
                    r_sq_v <= w_sq_v_n;
                    r_sq_r <= w_sq_r_n;
                    r_sq_k <= r_sq_k - 1'b1;
                end
            end
            S_SQM: begin
                r_sq_v <= w_sq_v_n;
                r_sq_r <= w_sq_r_n;
                r_sq_k <= r_sq_k - 1'b1;
                if (r_sq_k == '0) begin
                    r_nm <= w_sq_r_n[NORM_W-1:0];
                end
            end
            S_DEN: begin
                r_term <= '0;
            end
            S_CDIV: begin
                if (w_quot > DIV_NUM_W'(32768)) begin
                    r_c  <= COS_W'(32768);
                    r_pw <= COS_W'(32768);
                end else begin
                    r_c  <= w_quot[COS_W-1:0];
                    r_pw <= w_quot[COS_W-1:0];
                end
                r_pk <= w_peff - 1'b1;
            end
            S_POW: begin
                if (r_pk == '0) begin
                    r_term <= (w_neg && w_peff[0]) ? -TERM_W'({1'b0, r_pw})
                                                   : TERM_W'({1'b0, r_pw});
                end else begin
                    r_pw <= w_pround[COS_W+14:15];
                    r_pk <= r_pk - 1'b1;
                end
            end
            S_MST: begin
                r_mean <= '0;
            end
            S_MDIV: begin
                r_mean <= w_sneg ? -MEAN_W'(w_quot[MEAN_W-2:0])
                                 : MEAN_W'(w_quot[MEAN_W-2:0]);
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_osim <= SIM_W'(w_result);
                    r_ocnt <= CNT_OUT_W'(r_count);
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    assign out_ch.valid            = r_ovalid;
    assign out_ch.similarity_value = r_osim;
    assign out_ch.voxels_counted   = r_ocnt;

    // a result word appears only out of the output-load step
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_OUT)
        else $error("result word raised outside output load");

    // the count never passes its full mark
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_count[COUNT_BITS] && (r_count[COUNT_BITS-1:0] != '0)))
        else $error("foreground count beyond limit");

    // the divider is started only on the way into a wait for it
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |=> (r_state == S_CDIV || r_state == S_MDIV))
        else $error("divider started without a wait state");
endmodule
`default_nettype wire
